// ===== rtl/core/vwbf_pkg.sv =====
// types and constants shared by the variable width byte fifo
`timescale 1ns / 1ps
`default_nettype none
package vwbf_pkg;

  localparam int DATA_W   = 64;
  localparam int COUNT_W  = 4;
  localparam int FILL_W   = 11;
  localparam int CMD_W    = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [COUNT_W-1:0] byte_count;
    logic [DATA_W-1:0]  push_data;
  } in_beat_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic [COUNT_W-1:0] bytes_returned;
    logic [FILL_W-1:0]  fill_level;
    logic               overflow;
    logic               underflow;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic wr_step;
    logic rd_issue;
    logic rd_step;
    logic clear;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_push;
    logic is_read;
    logic is_clear;
    logic push_ok;
    logic len_nz;
    logic last;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/vwbf_datapath.sv =====
// byte ring, pointers, fill count and result register of the byte fifo
`timescale 1ns / 1ps
`default_nettype none
module vwbf_datapath #(
  parameter int DEPTH = 1024,
  parameter int LANES = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire vwbf_pkg::in_beat_t  in_data,
  input  wire vwbf_pkg::dp_cmd_t   cmd,
  output vwbf_pkg::dp_sts_t        sts,
  output vwbf_pkg::out_beat_t      out_data
);
  import vwbf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int NW = $clog2(LANES + 1);

  logic [7:0]        mem [DEPTH];
  logic [AW-1:0]     head_r;
  logic [AW-1:0]     tail_r;
  logic [CW-1:0]     count_r;
  logic [AW-1:0]     ptr_r;
  logic [LW-1:0]     idx_r;
  logic [NW-1:0]     len_r;
  logic [NW-1:0]     got_r;
  logic [CMD_W-1:0]  op_r;
  logic [DATA_W-1:0] pdata_r;
  logic [DATA_W-1:0] rdata_r;
  logic [7:0]        rd_q_r;
  logic              ovf_r;
  logic              unf_r;
  logic              push_ok_r;
  out_beat_t         out_r;

  logic [NW-1:0]     n_in;
  logic [CW-1:0]     n_ext;
  logic [CW-1:0]     space;
  logic              fits;
  logic              nz;
  logic              in_push;
  logic              in_read;
  logic              short_rd;
  logic [NW-1:0]     got_in;
  logic [AW-1:0]     ptr_nxt;
  logic              last;

  always_comb begin
    n_in     = (in_data.byte_count > COUNT_W'(LANES)) ? NW'(LANES)
                                                      : NW'(in_data.byte_count);
    n_ext    = CW'(n_in);
    space    = CW'(DEPTH) - count_r;
    fits     = (n_ext <= space);
    nz       = (n_in != '0);
    in_push  = (in_data.cmd == CMD_PUSH);
    in_read  = (in_data.cmd == CMD_POP) || (in_data.cmd == CMD_PEEK);
    short_rd = (n_ext > count_r);
    got_in   = short_rd ? NW'(count_r) : n_in;
    ptr_nxt  = (ptr_r == AW'(DEPTH - 1)) ? '0 : ptr_r + AW'(1);
    last     = (NW'(idx_r) == (len_r - NW'(1)));
  end

  assign sts.is_push  = (op_r == CMD_PUSH);
  assign sts.is_read  = (op_r == CMD_POP) || (op_r == CMD_PEEK);
  assign sts.is_clear = (op_r == CMD_CLEAR);
  assign sts.push_ok  = push_ok_r;
  assign sts.len_nz   = (len_r != '0);
  assign sts.last     = last;

  assign out_data = out_r;

  // byte ring
  always_ff @(posedge clk) begin
    if (cmd.wr_step) begin
      mem[ptr_r] <= pdata_r[7:0];
    end
    if (cmd.rd_issue) begin
      rd_q_r <= mem[ptr_r];
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (cmd.clear) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (cmd.wr_step && last) begin
      tail_r  <= ptr_nxt;
      count_r <= count_r + CW'(len_r);
    end else if (cmd.rd_step && last && (op_r == CMD_POP)) begin
      head_r  <= ptr_nxt;
      count_r <= count_r - CW'(len_r);
    end
  end

  // working registers of the current beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_data.cmd;
      pdata_r   <= in_data.push_data;
      ptr_r     <= in_push ? tail_r : head_r;
      idx_r     <= '0;
      len_r     <= in_push ? n_in : (in_read ? got_in : '0);
      got_r     <= in_read ? got_in : '0;
      ovf_r     <= in_push && nz && !fits;
      unf_r     <= in_read && short_rd;
      push_ok_r <= in_push && nz && fits;
      rdata_r   <= '0;
    end
    if (cmd.wr_step) begin
      pdata_r <= pdata_r >> 8;
      ptr_r   <= ptr_nxt;
      idx_r   <= idx_r + LW'(1);
    end
    if (cmd.rd_step) begin
      for (int l = 0; l < LANES; l++) begin
        if (idx_r == LW'(l)) begin
          rdata_r[l*8 +: 8] <= rd_q_r;
        end
      end
      ptr_r <= ptr_nxt;
      idx_r <= idx_r + LW'(1);
    end
    if (cmd.out_load) begin
      out_r.read_data      <= rdata_r;
      out_r.bytes_returned <= COUNT_W'(got_r);
      out_r.fill_level     <= FILL_W'(count_r);
      out_r.overflow       <= ovf_r;
      out_r.underflow      <= unf_r;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/vwbf_ctrl.sv =====
// sequencing state machine of the byte fifo
`timescale 1ns / 1ps
`default_nettype none
module vwbf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire vwbf_pkg::dp_sts_t sts,
  output vwbf_pkg::dp_cmd_t      cmd
);
  import vwbf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_WRITE,
    S_RD_ISSUE,
    S_RD_COLLECT,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_stall_r;
  logic   out_valid_r;
  logic   out_free;

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.is_clear) begin
          cmd.clear = 1'b1;
          state_nxt = S_FINISH;
        end else if (sts.is_push && sts.push_ok) begin
          state_nxt = S_WRITE;
        end else if (sts.is_read && sts.len_nz) begin
          state_nxt = S_RD_ISSUE;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_WRITE: begin
        cmd.wr_step = 1'b1;
        if (sts.last) begin
          state_nxt = S_FINISH;
        end
      end
      S_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RD_COLLECT;
      end
      S_RD_COLLECT: begin
        cmd.rd_step = 1'b1;
        state_nxt   = sts.last ? S_FINISH : S_RD_ISSUE;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/variable_width_byte_fifo_core.sv =====
// top level of the variable width byte fifo
// Byte-granular FIFO over a ring of DEPTH bytes. Each beat carries one command:
// push appends 1 to LANES bytes (rejected whole with overflow when it does not
// fit, ignored when empty), pop removes up to LANES bytes in order, peek
// returns them without removing them, clear empties the store. Missing bytes
// of a short read are zero and flag underflow; every result beat reports the
// fill level after the command. The byte ring has one port, so bytes move one
// at a time: a push writes its bytes in turn, a pop or peek issues and then
// collects each byte in turn, and clear, empty or rejected commands touch no
// byte. One command is in flight at a time; a new beat is accepted while the
// previous result still waits at the output. No clearing pass is needed after
// reset.
`timescale 1ns / 1ps
`default_nettype none
module variable_width_byte_fifo_core #(
  parameter int DEPTH = 1024,
  parameter int LANES = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire vwbf_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output vwbf_pkg::out_beat_t      out_data
);
  import vwbf_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  vwbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  vwbf_datapath #(
    .DEPTH (DEPTH),
    .LANES (LANES)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (dp_cmd),
    .sts      (dp_sts),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ===== dv/vwbf_checker.sv =====
// checker for the variable width byte fifo: predicts each result beat and compares it
`timescale 1ns / 1ps
module vwbf_checker
  import vwbf_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int LANES = 8
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire in_beat_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire out_beat_t out_data,
  output int             mismatches,
  output int             pending
);

  logic [7:0] ring_mem [DEPTH];
  int         head_idx;
  int         tail_idx;
  int         level;
  out_beat_t  want_beats [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // applies one command to the ring and returns the beat it should produce
  function automatic out_beat_t apply_cmd(input in_beat_t b);
    out_beat_t r;
    int        n;
    int        take;
    int        pos;
    int        i;
    r = '0;
    n = (b.byte_count > LANES) ? LANES : int'(b.byte_count);
    case (b.cmd)
      CMD_PUSH: begin
        if (n != 0) begin
          if (n > DEPTH - level) begin
            r.overflow = 1'b1;
          end else begin
            for (i = 0; i < n; i++) begin
              ring_mem[tail_idx] = b.push_data[8*i +: 8];
              tail_idx = (tail_idx + 1) % DEPTH;
            end
            level += n;
          end
        end
      end
      CMD_POP, CMD_PEEK: begin
        take = (n > level) ? level : n;
        r.underflow = (n > level);
        pos = head_idx;
        for (i = 0; i < take; i++) begin
          r.read_data[8*i +: 8] = ring_mem[pos];
          pos = (pos + 1) % DEPTH;
        end
        r.bytes_returned = take[COUNT_W-1:0];
        if (b.cmd == CMD_POP) begin
          head_idx = pos;
          level -= take;
        end
      end
      default: begin
        head_idx = 0;
        tail_idx = 0;
        level    = 0;
      end
    endcase
    r.fill_level = level[FILL_W-1:0];
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    if (mismatches < 200) begin
      $display("vwbf_checker: %s got %0h want %0h at %0t", what, got, want, $realtime);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    out_beat_t w;
    if (!rst_n) begin
      head_idx = 0;
      tail_idx = 0;
      level    = 0;
      want_beats.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (want_beats.size() == 0) begin
          report("result beat with nothing expected", out_data.read_data, '0);
        end else begin
          w = want_beats.pop_front();
          if (out_data.read_data !== w.read_data)
            report("read_data", out_data.read_data, w.read_data);
          if (out_data.bytes_returned !== w.bytes_returned)
            report("bytes_returned", 64'(out_data.bytes_returned), 64'(w.bytes_returned));
          if (out_data.fill_level !== w.fill_level)
            report("fill_level", 64'(out_data.fill_level), 64'(w.fill_level));
          if (out_data.overflow !== w.overflow)
            report("overflow", 64'(out_data.overflow), 64'(w.overflow));
          if (out_data.underflow !== w.underflow)
            report("underflow", 64'(out_data.underflow), 64'(w.underflow));
        end
      end
      if (in_valid && !in_stall) begin
        want_beats.push_back(apply_cmd(in_data));
      end
    end
    pending <= want_beats.size();
  end

endmodule

// ===== dv/tb_variable_width_byte_fifo_core.sv =====
// testbench top for the variable width byte fifo: stimulus, back-pressure and verdict
`timescale 1ns / 1ps
module tb_variable_width_byte_fifo_core;
  import vwbf_pkg::*;

  localparam int DEPTH = 1024;
  localparam int LANES = 8;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;
  int        mismatches;
  int        pending;
  bit        no_gaps;

  variable_width_byte_fifo_core #(
    .DEPTH(DEPTH),
    .LANES(LANES)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  vwbf_checker #(
    .DEPTH(DEPTH),
    .LANES(LANES)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic in_beat_t beat_of(input logic [CMD_W-1:0] c, input int n,
                                       input logic [DATA_W-1:0] d);
    in_beat_t b;
    b.cmd        = c;
    b.byte_count = n[COUNT_W-1:0];
    b.push_data  = d;
    return b;
  endfunction

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 15) return $urandom_range(9, 15);
    return $urandom_range(1, 8);
  endfunction

  function automatic in_beat_t rand_beat(input int w_push, input int w_pop,
                                         input int w_peek, input int w_clr);
    in_beat_t b;
    int       r;
    r = $urandom_range(0, w_push + w_pop + w_peek + w_clr - 1);
    if (r < w_push) b.cmd = CMD_PUSH;
    else if (r < w_push + w_pop) b.cmd = CMD_POP;
    else if (r < w_push + w_pop + w_peek) b.cmd = CMD_PEEK;
    else b.cmd = CMD_CLEAR;
    b.byte_count = COUNT_W'(pick_count());
    // filling runs mostly use full-width pushes so the ring fills quickly
    if (b.cmd == CMD_PUSH && w_push > 80 && $urandom_range(0, 1) == 1)
      b.byte_count = COUNT_W'(8);
    b.push_data = {$urandom, $urandom};
    return b;
  endfunction

  function automatic int idle_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_beat(input in_beat_t b);
    in_data  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic rest(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_empty();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_idle(input in_beat_t b);
    int g;
    send_beat(b);
    g = idle_len();
    if (g != 0) rest(g);
  endtask

  task automatic run_phase(input int count, input int w_push, input int w_pop,
                           input int w_peek, input int w_clr);
    for (int k = 0; k < count; k++) begin
      send_idle(rand_beat(w_push, w_pop, w_peek, w_clr));
    end
  endtask

  // output back-pressure
  initial begin
    int r;
    int len;
    bit v;
    out_stall = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        v   = 1'b0;
        len = $urandom_range(1, 20);
      end else if (r < 90) begin
        v   = 1'b1;
        len = $urandom_range(1, 3);
      end else begin
        v   = 1'b1;
        len = $urandom_range(8, 40);
      end
      repeat (len) begin
        @(posedge clk);
        out_stall <= v;
      end
    end
  end

  initial begin
    in_beat_t directed [$];
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    no_gaps  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty store, zero-byte commands, clamped counts, short reads and clear
    directed.push_back(beat_of(CMD_PUSH,  0, {$urandom, $urandom}));
    directed.push_back(beat_of(CMD_POP,   8, '0));
    directed.push_back(beat_of(CMD_PEEK,  0, '0));
    directed.push_back(beat_of(CMD_POP,   0, '0));
    directed.push_back(beat_of(CMD_PUSH,  8, 64'hFFFF_FFFF_FFFF_FFFF));
    directed.push_back(beat_of(CMD_PUSH,  1, '0));
    directed.push_back(beat_of(CMD_PUSH, 15, {$urandom, $urandom}));
    directed.push_back(beat_of(CMD_PUSH,  9, {$urandom, $urandom}));
    directed.push_back(beat_of(CMD_PEEK,  8, '0));
    directed.push_back(beat_of(CMD_PEEK, 15, 64'hFFFF_FFFF_FFFF_FFFF));
    directed.push_back(beat_of(CMD_POP,   3, '0));
    directed.push_back(beat_of(CMD_POP,   0, '0));
    directed.push_back(beat_of(CMD_PEEK,  0, '0));
    directed.push_back(beat_of(CMD_POP,  15, '0));
    directed.push_back(beat_of(CMD_POP,   8, '0));
    directed.push_back(beat_of(CMD_POP,   8, '0));
    directed.push_back(beat_of(CMD_PUSH,  4, {$urandom, $urandom}));
    directed.push_back(beat_of(CMD_CLEAR, 15, 64'hFFFF_FFFF_FFFF_FFFF));
    directed.push_back(beat_of(CMD_PEEK,  8, '0));
    directed.push_back(beat_of(CMD_PUSH,  8, '0));
    directed.push_back(beat_of(CMD_POP,  15, '0));
    directed.push_back(beat_of(CMD_CLEAR, 0, '0));
    directed.push_back(beat_of(CMD_PUSH,  5, 64'hFFFF_FFFF_FFFF_FFFF));
    foreach (directed[k]) send_idle(directed[k]);

    run_phase(130, 45, 30, 20, 3);
    wait_empty();
    // back-to-back push-heavy run without gaps to fill the ring
    no_gaps = 1'b1;
    run_phase(150, 92, 4, 4, 0);
    no_gaps = 1'b0;
    wait_empty();
    run_phase(130, 15, 65, 20, 0);
    run_phase(60, 40, 30, 25, 5);
    wait_empty();
    repeat (40) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
